// File: rtl/vvl_pkg.sv
// Shared types and constants for the voltage vector limiter.
`timescale 1ns / 1ps

package vvl_pkg;

   // 1/sqrt(3) in unsigned Q0.16
   localparam int unsigned Q_FRAC = 16;
   localparam logic [Q_FRAC-1:0] INV_SQRT3_Q16 = 16'd37837;

   // Control that travels with each transaction through the pipeline
   typedef struct packed {
      logic valid;
      logic d_neg;
      logic q_neg;
      logic limited;
   } vvl_ctl_type;

endpackage

// File: rtl/vvl_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module vvl_isqrt #(
   parameter int ROOT_W = 16,
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vvl_pkg::vvl_ctl_type      in_ctl,
   input  logic [2*ROOT_W-1:0]       in_rad,
   input  logic [SIDE_W-1:0]         in_side,
   output vvl_pkg::vvl_ctl_type      out_ctl,
   output logic [ROOT_W-1:0]         out_root,
   output logic [SIDE_W-1:0]         out_side
);
   import vvl_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   vvl_ctl_type         ctl_ff  [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         vvl_ctl_type       prev_ctl;
         logic [REM_W-1:0]  prev_rem;
         logic [ROOT_W-1:0] prev_root;
         logic [RAD_W-1:0]  prev_rad;
         logic [SIDE_W-1:0] prev_side;
         logic [REM_W-1:0]  shifted;
         logic [REM_W-1:0]  trial;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign prev_ctl  = in_ctl;
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_rad  = in_rad;
            assign prev_side = in_side;
         end else begin : g_next
            assign prev_ctl  = ctl_ff[k-1];
            assign prev_rem  = rem_ff[k-1];
            assign prev_root = root_ff[k-1];
            assign prev_rad  = rad_ff[k-1];
            assign prev_side = side_ff[k-1];
         end

         // bring down the next two radicand bits and try one root bit
         always_comb begin
            shifted = {prev_rem[REM_W-3:0], prev_rad[RAD_W-1-2*k -: 2]};
            trial   = {1'b0, prev_root, 2'b01};
            if (shifted >= trial) begin
               rem_in  = shifted - trial;
               root_in = {prev_root[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               root_in = {prev_root[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else begin
               ctl_ff[k] <= prev_ctl;
            end
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= prev_rad;
            side_ff[k] <= prev_side;
         end
      end
   endgenerate

   assign out_ctl  = ctl_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

   // root is the floor of the square root of the radicand
   a_root_low: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |->
         ({{ROOT_W{1'b0}}, out_root} * {{ROOT_W{1'b0}}, out_root}) <= rad_ff[ROOT_W-1])
      else $error("square root too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |->
         ({{(ROOT_W+1){1'b0}}, {1'b0, out_root} + {{ROOT_W{1'b0}}, 1'b1}} *
          {{(ROOT_W+1){1'b0}}, {1'b0, out_root} + {{ROOT_W{1'b0}}, 1'b1}})
         > {2'b00, rad_ff[ROOT_W-1]})
      else $error("square root too small");

endmodule

// File: rtl/vvl_div.sv
// Pipelined dual restoring divider sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module vvl_div #(
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vvl_pkg::vvl_ctl_type   in_ctl,
   input  logic [QUO_W-1:0]       in_den,
   input  logic [2*QUO_W-1:0]     in_num_d,
   input  logic [2*QUO_W-1:0]     in_num_q,
   input  logic [SIDE_W-1:0]      in_side,
   output vvl_pkg::vvl_ctl_type   out_ctl,
   output logic [QUO_W-1:0]       out_quo_d,
   output logic [QUO_W-1:0]       out_quo_q,
   output logic [SIDE_W-1:0]      out_side
);
   import vvl_pkg::*;

   localparam int NUM_W = 2 * QUO_W;

   vvl_ctl_type        ctl_ff   [QUO_W];
   logic [QUO_W-1:0]   den_ff   [QUO_W];
   logic [NUM_W-1:0]   numd_ff  [QUO_W];
   logic [NUM_W-1:0]   numq_ff  [QUO_W];
   logic [QUO_W-1:0]   remd_ff  [QUO_W];
   logic [QUO_W-1:0]   remq_ff  [QUO_W];
   logic [QUO_W-1:0]   quod_ff  [QUO_W];
   logic [QUO_W-1:0]   quoq_ff  [QUO_W];
   logic [SIDE_W-1:0]  side_ff  [QUO_W];

   // one restoring step: returns {new remainder, quotient bit}
   function automatic logic [QUO_W:0] div_step(input logic [QUO_W-1:0] rem,
                                               input logic             nbit,
                                               input logic [QUO_W-1:0] den);
      logic [QUO_W:0] sh;
      logic [QUO_W:0] diff;
      sh   = {rem, nbit};
      diff = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         div_step = {diff[QUO_W-1:0], 1'b1};
      end else begin
         div_step = {sh[QUO_W-1:0], 1'b0};
      end
   endfunction

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         vvl_ctl_type       prev_ctl;
         logic [QUO_W-1:0]  prev_den;
         logic [NUM_W-1:0]  prev_numd;
         logic [NUM_W-1:0]  prev_numq;
         logic [QUO_W-1:0]  prev_remd;
         logic [QUO_W-1:0]  prev_remq;
         logic [QUO_W-1:0]  prev_quod;
         logic [QUO_W-1:0]  prev_quoq;
         logic [SIDE_W-1:0] prev_side;
         logic [QUO_W:0]    stepd_in;
         logic [QUO_W:0]    stepq_in;

         if (k == 0) begin : g_first
            assign prev_ctl  = in_ctl;
            assign prev_den  = in_den;
            assign prev_numd = in_num_d;
            assign prev_numq = in_num_q;
            assign prev_remd = in_num_d[NUM_W-1:QUO_W];
            assign prev_remq = in_num_q[NUM_W-1:QUO_W];
            assign prev_quod = '0;
            assign prev_quoq = '0;
            assign prev_side = in_side;
         end else begin : g_next
            assign prev_ctl  = ctl_ff[k-1];
            assign prev_den  = den_ff[k-1];
            assign prev_numd = numd_ff[k-1];
            assign prev_numq = numq_ff[k-1];
            assign prev_remd = remd_ff[k-1];
            assign prev_remq = remq_ff[k-1];
            assign prev_quod = quod_ff[k-1];
            assign prev_quoq = quoq_ff[k-1];
            assign prev_side = side_ff[k-1];
         end

         // bring down the next dividend bit for both numerators
         assign stepd_in = div_step(prev_remd, prev_numd[QUO_W-1-k], prev_den);
         assign stepq_in = div_step(prev_remq, prev_numq[QUO_W-1-k], prev_den);

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else begin
               ctl_ff[k] <= prev_ctl;
            end
            den_ff[k]  <= prev_den;
            numd_ff[k] <= prev_numd;
            numq_ff[k] <= prev_numq;
            remd_ff[k] <= stepd_in[QUO_W:1];
            remq_ff[k] <= stepq_in[QUO_W:1];
            quod_ff[k] <= {prev_quod[QUO_W-2:0], stepd_in[0]};
            quoq_ff[k] <= {prev_quoq[QUO_W-2:0], stepq_in[0]};
            side_ff[k] <= prev_side;
         end
      end
   endgenerate

   assign out_ctl   = ctl_ff[QUO_W-1];
   assign out_quo_d = quod_ff[QUO_W-1];
   assign out_quo_q = quoq_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

   // quotient and remainder reproduce the dividend when the quotient fits
   a_div_d: assert property (@(posedge clock) disable iff (reset)
      (out_ctl.valid && den_ff[QUO_W-1] != '0 &&
       numd_ff[QUO_W-1][NUM_W-1:QUO_W] < den_ff[QUO_W-1]) |->
         (remd_ff[QUO_W-1] < den_ff[QUO_W-1] &&
          ({{QUO_W{1'b0}}, out_quo_d} * {{QUO_W{1'b0}}, den_ff[QUO_W-1]} +
           {{QUO_W{1'b0}}, remd_ff[QUO_W-1]}) == numd_ff[QUO_W-1]))
      else $error("d division mismatch");

   a_div_q: assert property (@(posedge clock) disable iff (reset)
      (out_ctl.valid && den_ff[QUO_W-1] != '0 &&
       numq_ff[QUO_W-1][NUM_W-1:QUO_W] < den_ff[QUO_W-1]) |->
         (remq_ff[QUO_W-1] < den_ff[QUO_W-1] &&
          ({{QUO_W{1'b0}}, out_quo_q} * {{QUO_W{1'b0}}, den_ff[QUO_W-1]} +
           {{QUO_W{1'b0}}, remq_ff[QUO_W-1]}) == numq_ff[QUO_W-1]))
      else $error("q division mismatch");

endmodule

// File: rtl/voltage_vector_limit.sv
// Top level of the circular d/q voltage vector limiter.
`timescale 1ns / 1ps

// Circular limit on a d/q voltage vector. The limit is bus voltage times
// 1/sqrt(3); a vector whose magnitude exceeds it is scaled back onto the
// circle with its phase kept, each component truncated toward zero, and
// rsp_was_limited is set. A vector within the limit passes unchanged. A
// transaction is taken at every cycle with start high; busy never rises.
// Each result appears for one cycle on rsp_strobe, after passing through four
// stages of magnitude, limit and square arithmetic, VOLT_WIDTH stages of the
// bit-per-stage square root, VOLT_WIDTH stages of the bit-per-stage divider
// and one output register.
// The receiver cannot stall, so results must be taken as they come.
module voltage_vector_limit #(
   parameter int VOLT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VOLT_WIDTH-1:0] req_bus_voltage,
   input  logic [VOLT_WIDTH-1:0] req_d_voltage_in,
   input  logic [VOLT_WIDTH-1:0] req_q_voltage_in,
   output logic                  rsp_strobe,
   output logic [VOLT_WIDTH-1:0] rsp_d_voltage_out,
   output logic [VOLT_WIDTH-1:0] rsp_q_voltage_out,
   output logic                  rsp_was_limited
);
   import vvl_pkg::*;

   localparam int W     = VOLT_WIDTH;
   localparam int PROD_W = W + Q_FRAC;

   // stage 1: magnitudes and bus scaling
   vvl_ctl_type      ctl1_ff;
   logic [PROD_W-1:0] busk1_ff;
   logic [W-1:0]     dm1_ff, qm1_ff;
   vvl_ctl_type      ctl1_in;
   logic [W-1:0]     dm1_in, qm1_in;

   // stage 2: limit
   vvl_ctl_type      ctl2_ff;
   logic [W-1:0]     lim2_ff, dm2_ff, qm2_ff;

   // stage 3: squares and numerators
   vvl_ctl_type      ctl3_ff;
   logic [2*W-1:0]   dsq3_ff, qsq3_ff, lsq3_ff, nd3_ff, nq3_ff;
   logic [W-1:0]     dm3_ff, qm3_ff;

   // stage 4: squared magnitude and compare
   vvl_ctl_type      ctl4_ff, ctl4_in;
   logic [2*W-1:0]   sum4_ff, sum4_in, nd4_ff, nq4_ff;
   logic [W-1:0]     dm4_ff, qm4_ff;

   // square root and divider links
   vvl_ctl_type      sq_ctl;
   logic [W-1:0]     sq_root;
   logic [6*W-1:0]   sq_side;
   vvl_ctl_type      dv_ctl;
   logic [W-1:0]     dv_quo_d, dv_quo_q;
   logic [2*W-1:0]   dv_side;
   logic [W-1:0]     dv_dm, dv_qm;

   // output register
   logic             strobe_ff;
   logic [W-1:0]     dout_ff, qout_ff;
   logic             lim_ff;
   logic [W-1:0]     dout_in, qout_in;

   assign busy = 1'b0;

   // split signed inputs into magnitude and sign
   always_comb begin
      ctl1_in.valid   = start;
      ctl1_in.d_neg   = req_d_voltage_in[W-1];
      ctl1_in.q_neg   = req_q_voltage_in[W-1];
      ctl1_in.limited = 1'b0;
      dm1_in = req_d_voltage_in[W-1] ? (~req_d_voltage_in + 1'b1) : req_d_voltage_in;
      qm1_in = req_q_voltage_in[W-1] ? (~req_q_voltage_in + 1'b1) : req_q_voltage_in;
   end

   // squared magnitude against squared limit
   always_comb begin
      sum4_in = dsq3_ff + qsq3_ff;
      ctl4_in = ctl3_ff;
      ctl4_in.limited = (sum4_in > lsq3_ff);
   end

   // advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl4_in;
      end
      busk1_ff <= {{Q_FRAC{1'b0}}, req_bus_voltage} * {{W{1'b0}}, INV_SQRT3_Q16};
      dm1_ff   <= dm1_in;
      qm1_ff   <= qm1_in;

      lim2_ff  <= busk1_ff[PROD_W-1:Q_FRAC];
      dm2_ff   <= dm1_ff;
      qm2_ff   <= qm1_ff;

      dsq3_ff  <= {{W{1'b0}}, dm2_ff} * {{W{1'b0}}, dm2_ff};
      qsq3_ff  <= {{W{1'b0}}, qm2_ff} * {{W{1'b0}}, qm2_ff};
      lsq3_ff  <= {{W{1'b0}}, lim2_ff} * {{W{1'b0}}, lim2_ff};
      nd3_ff   <= {{W{1'b0}}, dm2_ff} * {{W{1'b0}}, lim2_ff};
      nq3_ff   <= {{W{1'b0}}, qm2_ff} * {{W{1'b0}}, lim2_ff};
      dm3_ff   <= dm2_ff;
      qm3_ff   <= qm2_ff;

      sum4_ff  <= sum4_in;
      nd4_ff   <= nd3_ff;
      nq4_ff   <= nq3_ff;
      dm4_ff   <= dm3_ff;
      qm4_ff   <= qm3_ff;
   end

   vvl_isqrt #(
      .ROOT_W (W),
      .SIDE_W (6*W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ctl4_ff),
      .in_rad   (sum4_ff),
      .in_side  ({nd4_ff, nq4_ff, dm4_ff, qm4_ff}),
      .out_ctl  (sq_ctl),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   vvl_div #(
      .QUO_W  (W),
      .SIDE_W (2*W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sq_ctl),
      .in_den    (sq_root),
      .in_num_d  (sq_side[6*W-1:4*W]),
      .in_num_q  (sq_side[4*W-1:2*W]),
      .in_side   (sq_side[2*W-1:0]),
      .out_ctl   (dv_ctl),
      .out_quo_d (dv_quo_d),
      .out_quo_q (dv_quo_q),
      .out_side  (dv_side)
   );

   assign dv_dm = dv_side[2*W-1:W];
   assign dv_qm = dv_side[W-1:0];

   // pick scaled or original magnitude and restore the sign
   always_comb begin
      logic [W-1:0] dmag;
      logic [W-1:0] qmag;
      dmag = dv_ctl.limited ? dv_quo_d : dv_dm;
      qmag = dv_ctl.limited ? dv_quo_q : dv_qm;
      dout_in = dv_ctl.d_neg ? (~dmag + 1'b1) : dmag;
      qout_in = dv_ctl.q_neg ? (~qmag + 1'b1) : qmag;
   end

   // hold the result for its strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_ctl.valid;
      end
      dout_ff <= dout_in;
      qout_ff <= qout_in;
      lim_ff  <= dv_ctl.limited;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_d_voltage_out = dout_ff;
   assign rsp_q_voltage_out = qout_ff;
   assign rsp_was_limited   = lim_ff;

endmodule
